@@ sv/assert_macros.svh @@
// assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every rising clock edge outside reset
`define LRUC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// property must never hold at a rising clock edge outside reset
`define LRUC_ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);

`else

`define LRUC_ASSERT(lbl, clk, rstn, prop, msg)
`define LRUC_ASSERT_NEVER(lbl, clk, rstn, prop, msg)

`endif

`endif

@@ sv/lruc_pkg.sv @@
package lruc_pkg;

  localparam int unsigned ENTRIES   = 16;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned YEAR_W    = 9;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned KEY_W     = YEAR_W + MONTH_W + DAY_W;
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned CNT_W     = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int unsigned CAP_RESET = 16;

  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_GET = 1'b1;

  // one cache line held by a cell
  typedef struct packed {
    logic                 valid;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  // passed from the older neighbor toward the front
  typedef struct packed {
    logic                 hit;   // a match sits at this or an older position
    logic [PAYLOAD_W-1:0] data;  // payload of the matching line, else zero
  } tail_t;

  // broadcast to every cell
  typedef struct packed {
    logic             cmp_en;
    logic [KEY_W-1:0] key;
    logic             upd_en;
    logic             hit;
    logic             add;
    logic             full;
  } cell_ctl_t;

endpackage

@@ sv/lruc_if.sv @@
interface lruc_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [lruc_pkg::YEAR_W-1:0]   key_year;
  logic [lruc_pkg::MONTH_W-1:0]  key_month;
  logic [lruc_pkg::DAY_W-1:0]    key_day;
  logic [lruc_pkg::PAYLOAD_W-1:0] write_data;

  modport source (output valid, req_type, key_year, key_month, key_day, write_data,
                  input ready);
  modport sink (input valid, req_type, key_year, key_month, key_day, write_data,
                output ready);
endinterface

interface lruc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [lruc_pkg::PAYLOAD_W-1:0] read_data;
  logic                          evicted;

  modport source (output valid, found, read_data, evicted, input ready);
  modport sink (input valid, found, read_data, evicted, output ready);
endinterface

@@ sv/lruc_cell.sv @@
module lruc_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lruc_pkg::cell_ctl_t ctl_i,
  input  lruc_pkg::entry_t    prev_i,   // younger neighbor, or the new front line
  input  lruc_pkg::tail_t     tail_i,   // from the older neighbor
  output lruc_pkg::entry_t    entry_o,
  output lruc_pkg::tail_t     tail_o
);

  logic                           valid_q;
  logic [lruc_pkg::KEY_W-1:0]     key_q;
  logic [lruc_pkg::PAYLOAD_W-1:0] payload_q;
  logic                           match_q, match_d;
  logic                           shift;

  assign match_d = ctl_i.cmp_en ? (valid_q && (key_q == ctl_i.key)) : match_q;

  assign tail_o.hit  = match_q | tail_i.hit;
  assign tail_o.data = (match_q ? payload_q : '0) | tail_i.data;

  // hit: everything from the front down to the hit line moves one step older
  // miss add: the filled region moves, growing by one unless full
  always_comb begin
    shift = 1'b0;
    if (ctl_i.upd_en) begin
      if (ctl_i.hit) begin
        shift = match_q | tail_i.hit;
      end else if (ctl_i.add) begin
        shift = valid_q | (!ctl_i.full & prev_i.valid);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
      if (shift) begin
        valid_q <= prev_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      key_q     <= prev_i.key;
      payload_q <= prev_i.payload;
    end
  end

  assign entry_o.valid   = valid_q;
  assign entry_o.key     = key_q;
  assign entry_o.payload = payload_q;

endmodule

@@ sv/lru_date_keyed_cache.sv @@
// date keyed lru cache: up to lruc_pkg::ENTRIES lines kept in a chain of cells
// ordered by recency, the front cell being the most recently used line. when a
// request word is accepted every cell compares its key with the request key; in the
// update state the chain then shifts once (move to front on a hit, insert at the
// front on a miss add, dropping the oldest line when full; a miss get does not
// shift) and the response word is loaded. no new request word is accepted until
// that shift is done. a response waiting in the output register does not block
// accepting a new request; only the shift step waits for the output register to
// free up. capacity (1..ENTRIES, zero acts as one, larger values saturate) is
// written through cfg_we_i; the user writes it only while idle, the block does not
// enforce it. no clearing pass: all lines are invalid right after reset.
`include "assert_macros.svh"

module lru_date_keyed_cache (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lruc_pkg::CAP_W-1:0] cfg_wdata_i,
  lruc_req_if.sink                   req_i,
  lruc_rsp_if.source                 rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } state_e;

  state_e st_q, st_d;

  // capacity register and fill count
  logic [lruc_pkg::CAP_W-1:0] cap_q;
  logic [lruc_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [lruc_pkg::CNT_W-1:0] eff_cap;

  // latched request word
  logic                           req_type_q;
  logic [lruc_pkg::KEY_W-1:0]     key_q;
  logic [lruc_pkg::PAYLOAD_W-1:0] wdata_q;

  // response register
  logic                           rsp_valid_q;
  logic                           found_q;
  logic [lruc_pkg::PAYLOAD_W-1:0] read_data_q;
  logic                           evicted_q;

  logic accept, commit;
  logic hit_any, is_add, is_full, grow;

  lruc_pkg::cell_ctl_t ctl;
  lruc_pkg::entry_t    front;
  lruc_pkg::entry_t    ent   [lruc_pkg::ENTRIES];
  lruc_pkg::tail_t     tail  [lruc_pkg::ENTRIES];
  logic [lruc_pkg::ENTRIES-1:0] valid_vec;

  logic [lruc_pkg::KEY_W-1:0] in_key;

  assign in_key = {req_i.key_year, req_i.key_month, req_i.key_day};

  // handshakes
  assign req_i.ready = (st_q == ST_IDLE);
  assign accept      = req_i.valid & req_i.ready;
  // the shift happens only once the response register can take the result
  assign commit      = (st_q == ST_UPD) & (!rsp_valid_q | rsp_o.ready);

  // effective capacity: zero acts as one, saturate at the cell count
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = lruc_pkg::CNT_W'(1);
    end else if (lruc_pkg::CMP_W'(cap_q) > lruc_pkg::CMP_W'(lruc_pkg::ENTRIES)) begin
      eff_cap = lruc_pkg::CNT_W'(lruc_pkg::ENTRIES);
    end else begin
      eff_cap = lruc_pkg::CNT_W'(cap_q);
    end
  end

  assign hit_any = tail[0].hit;
  assign is_add  = (req_type_q == lruc_pkg::REQ_ADD);
  assign is_full = (cnt_q >= eff_cap);
  assign grow    = is_add & !hit_any & !is_full;

  always_comb begin
    cnt_d = cnt_q;
    if (commit && grow) begin
      cnt_d = cnt_q + lruc_pkg::CNT_W'(1);
    end
  end

  // line entering the front cell: the hit line moved up, or the new line
  assign front.valid   = 1'b1;
  assign front.key     = key_q;
  assign front.payload = (hit_any && !is_add) ? tail[0].data : wdata_q;

  assign ctl.cmp_en = accept;
  assign ctl.key    = in_key;
  assign ctl.upd_en = commit;
  assign ctl.hit    = hit_any;
  assign ctl.add    = is_add;
  assign ctl.full   = is_full;

  // the cell chain
  for (genvar i = 0; i < lruc_pkg::ENTRIES; i++) begin : g_cell
    lruc_pkg::entry_t prev;
    lruc_pkg::tail_t  older;

    if (i == 0) begin : g_front
      assign prev = front;
    end else begin : g_mid
      assign prev = ent[i-1];
    end

    if (i == lruc_pkg::ENTRIES - 1) begin : g_last
      assign older = '0;
    end else begin : g_inner
      assign older = tail[i+1];
    end

    lruc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .prev_i  (prev),
      .tail_i  (older),
      .entry_o (ent[i]),
      .tail_o  (tail[i])
    );

    assign valid_vec[i] = ent[i].valid;
  end

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          st_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (commit) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cap_q       <= lruc_pkg::CAP_W'(lruc_pkg::CAP_RESET);
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (commit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // request and response payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q <= req_i.req_type;
      key_q      <= in_key;
      wdata_q    <= req_i.write_data;
    end
    if (commit) begin
      found_q     <= hit_any;
      read_data_q <= (hit_any && !is_add) ? tail[0].data : '0;
      evicted_q   <= is_add & !hit_any & is_full;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.found     = found_q;
  assign rsp_o.read_data = read_data_q;
  assign rsp_o.evicted   = evicted_q;

  // checks
  `LRUC_ASSERT(a_fill_matches_valid, clk_i, rst_ni,
    $countones(valid_vec) == 32'(cnt_q), "fill count differs from valid lines")
  `LRUC_ASSERT(a_accept_to_upd, clk_i, rst_ni,
    accept |=> (st_q == ST_UPD), "accepted request did not reach the shift step")
  `LRUC_ASSERT(a_grow_counts, clk_i, rst_ni,
    (commit && grow) |=> (cnt_q == $past(cnt_q) + lruc_pkg::CNT_W'(1)),
    "new line did not raise the fill count")
  `LRUC_ASSERT_NEVER(a_evict_on_hit, clk_i, rst_ni,
    rsp_valid_q && found_q && evicted_q, "eviction reported on a hit")

endmodule

@@ verif/tb_lru_date_keyed_cache.sv @@
`timescale 1ns / 1ps

module tb_lru_date_keyed_cache;
  import lruc_pkg::*;

  // cycles with no accepted word before the run is called hung
  localparam int unsigned IDLE_LIMIT    = 4000;
  // receiver hold-off used to back the block up into its request side
  localparam int unsigned LONG_HOLD     = 300;
  // quiet cycles after the last response before touching capacity
  localparam int unsigned SETTLE_CYCLES = 8;

  // request word as the sender sees it
  typedef struct packed {
    logic                 req_type;
    logic [YEAR_W-1:0]    year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
    logic [PAYLOAD_W-1:0] data;
  } cache_req_t;

  // response word as the receiver sees it
  typedef struct packed {
    logic                 found;
    logic [PAYLOAD_W-1:0] read_data;
    logic                 evicted;
  } cache_rsp_t;

  // shadow copy of the cache lines plus the queue of responses still owed
  class cache_scoreboard;
    logic [CAP_W-1:0]     cap_reg;
    bit                   line_valid [ENTRIES];
    logic [KEY_W-1:0]     line_key   [ENTRIES];
    logic [PAYLOAD_W-1:0] line_data  [ENTRIES];
    int unsigned          line_rank  [ENTRIES];
    int unsigned          fill;
    cache_rsp_t           due_rsp [$];
    int unsigned          errors;

    function new();
      cap_reg = CAP_W'(CAP_RESET);
      fill    = 0;
      errors  = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        line_valid[i] = 1'b0;
        line_rank[i]  = 0;
      end
    endfunction

    function void write_capacity(logic [CAP_W-1:0] value);
      cap_reg = value;
    endfunction

    // zero behaves as one, anything past the line count saturates
    function int unsigned usable_lines();
      if (cap_reg == '0) return 1;
      if (cap_reg > ENTRIES) return ENTRIES;
      return cap_reg;
    endfunction

    // every valid line more recent than limit gets one step older
    function void age_lines(int unsigned limit);
      for (int i = 0; i < ENTRIES; i++)
        if (line_valid[i] && line_rank[i] < limit) line_rank[i]++;
    endfunction

    // update the shadow lines for one accepted request and queue its response
    function void note_request(cache_req_t w);
      logic [KEY_W-1:0] key;
      cache_rsp_t       want;
      int               hit;
      int               victim;
      int               slot;
      key    = {w.year, w.month, w.day};
      want   = '0;
      hit    = -1;
      victim = -1;
      slot   = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (hit < 0 && line_valid[i] && line_key[i] == key) hit = i;
      if (hit >= 0) begin
        // hit: move to front, read or overwrite the payload
        want.found = 1'b1;
        age_lines(line_rank[hit]);
        line_rank[hit] = 0;
        if (w.req_type == REQ_GET) want.read_data = line_data[hit];
        else line_data[hit] = w.data;
      end else if (w.req_type == REQ_ADD) begin
        // miss add: drop the oldest line once the fill reaches capacity
        if (fill >= usable_lines()) begin
          for (int i = 0; i < ENTRIES; i++)
            if (line_valid[i] && (victim < 0 || line_rank[i] > line_rank[victim])) victim = i;
          line_valid[victim] = 1'b0;
          fill--;
          want.evicted = 1'b1;
        end
        for (int i = 0; i < ENTRIES; i++)
          if (slot < 0 && !line_valid[i]) slot = i;
        age_lines(32'hFFFF_FFFF);
        line_valid[slot] = 1'b1;
        line_key[slot]   = key;
        line_data[slot]  = w.data;
        line_rank[slot]  = 0;
        fill++;
      end
      due_rsp.push_back(want);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 100) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // compare one accepted response word with the oldest one owed
    task check_response(cache_rsp_t got);
      cache_rsp_t want;
      if (due_rsp.size() == 0) begin
        report("response word with nothing owed");
        return;
      end
      want = due_rsp.pop_front();
      if (got.found !== want.found)
        report($sformatf("found %0b, want %0b", got.found, want.found));
      if (got.read_data !== want.read_data)
        report($sformatf("read_data %08h, want %08h", got.read_data, want.read_data));
      if (got.evicted !== want.evicted)
        report($sformatf("evicted %0b, want %0b", got.evicted, want.evicted));
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;

  lruc_req_if req_if ();
  lruc_rsp_if rsp_if ();

  lru_date_keyed_cache u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  cache_scoreboard sb = new();

  // knobs the main sequence sets per phase
  bit          send_quiet = 1'b0;
  bit          recv_quiet = 1'b0;
  int unsigned hold_asks  = 0;
  int unsigned idle_cycles = 0;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // receiver: random stalls, plus the long hold-off when asked
  initial begin
    int unsigned stall_left;
    int unsigned hold_seen;
    stall_left = 0;
    hold_seen  = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_asks) begin
        hold_seen  = hold_asks;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        stall_left = recv_quiet ? 0 : pick_gap();
      end
    end
  end

  // response monitor: every accepted word goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
      sb.check_response('{found: rsp_if.found, read_data: rsp_if.read_data,
                          evicted: rsp_if.evicted});
  end

  // watchdog on cycles where neither side moves a word
  always @(posedge clk_i) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one request word and wait for the accept edge; the caller is
  // always just past a rising edge, so valid gets one assignment per step
  task automatic send_request(cache_req_t w);
    int unsigned gap;
    gap = send_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= w.req_type;
    req_if.key_year   <= w.year;
    req_if.key_month  <= w.month;
    req_if.key_day    <= w.day;
    req_if.write_data <= w.data;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.note_request(w);
  endtask

  task automatic send_fields(logic t, logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                             logic [DAY_W-1:0] d, logic [PAYLOAD_W-1:0] data);
    send_request('{req_type: t, year: y, month: m, day: d, data: data});
  endtask

  // stop offering, wait for every owed response, then let the block settle
  task automatic drain_and_settle();
    req_if.valid <= 1'b0;
    while (sb.due_rsp.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // capacity write, only with the block idle
  task automatic set_capacity(logic [CAP_W-1:0] value);
    drain_and_settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_capacity(value);
  endtask

  // random traffic over a small pool of keys so hits and evictions both
  // happen; a tenth of the keys are fresh random noise
  task automatic run_traffic(int unsigned count, int unsigned pool_n, bit quiet,
                             bit long_hold);
    logic [KEY_W-1:0] key_pool [$];
    logic [KEY_W-1:0] key;
    cache_req_t       w;
    key_pool.delete();
    for (int i = 0; i < pool_n; i++) key_pool.push_back(KEY_W'($urandom));
    send_quiet = quiet;
    recv_quiet = quiet;
    if (long_hold) hold_asks++;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) key = KEY_W'($urandom);
      else key = key_pool[$urandom_range(0, pool_n - 1)];
      w.req_type = $urandom_range(0, 1) ? REQ_GET : REQ_ADD;
      {w.year, w.month, w.day} = key;
      w.data = $urandom;
      send_request(w);
    end
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
  endtask

  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_ADD;
    req_if.key_year   <= '0;
    req_if.key_month  <= '0;
    req_if.key_day    <= '0;
    req_if.write_data <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty cache, extreme keys, update in place
    send_fields(REQ_GET, 9'd0,   4'd0,  5'd0,  32'h0000_0000);
    send_fields(REQ_ADD, 9'd0,   4'd0,  5'd0,  32'h0000_0000);
    send_fields(REQ_ADD, 9'd511, 4'd15, 5'd31, 32'hFFFF_FFFF);
    send_fields(REQ_GET, 9'd511, 4'd15, 5'd31, 32'h0000_0000);
    send_fields(REQ_GET, 9'd0,   4'd0,  5'd0,  32'hFFFF_FFFF);
    send_fields(REQ_ADD, 9'd0,   4'd0,  5'd0,  32'hA5A5_A5A5);
    send_fields(REQ_GET, 9'd0,   4'd0,  5'd0,  32'h0000_0000);
    // out-of-range month and a day of zero are plain key bits
    send_fields(REQ_ADD, 9'd0,   4'd12, 5'd0,  32'h1234_5678);
    // keys one field apart must stay distinct
    send_fields(REQ_ADD, 9'd0,   4'd0,  5'd1,  32'h0000_0001);
    send_fields(REQ_ADD, 9'd1,   4'd0,  5'd0,  32'h0000_0002);
    send_fields(REQ_ADD, 9'd0,   4'd1,  5'd0,  32'h0000_0003);
    send_fields(REQ_GET, 9'd0,   4'd12, 5'd0,  32'h0000_0000);
    send_fields(REQ_GET, 9'd0,   4'd0,  5'd1,  32'h0000_0000);
    send_fields(REQ_GET, 9'd1,   4'd0,  5'd0,  32'h0000_0000);
    send_fields(REQ_GET, 9'd0,   4'd1,  5'd0,  32'h0000_0000);
    // near miss and plain miss
    send_fields(REQ_GET, 9'd511, 4'd15, 5'd30, 32'h0000_0000);
    send_fields(REQ_GET, 9'd255, 4'd7,  5'd16, 32'h0000_0000);
    send_fields(REQ_ADD, 9'd256, 4'd8,  5'd15, 32'h5A5A_5A5A);
    send_fields(REQ_GET, 9'd256, 4'd8,  5'd15, 32'h0000_0000);
    send_fields(REQ_ADD, 9'd511, 4'd15, 5'd31, 32'h0000_0000);
    send_fields(REQ_GET, 9'd511, 4'd15, 5'd31, 32'h0000_0000);

    // full size first, fills and starts evicting
    run_traffic(70, 22, 1'b0, 1'b0);
    // lowered well below the fill
    set_capacity(5'd3);
    run_traffic(60, 6, 1'b0, 1'b0);
    // zero acts as one
    set_capacity(5'd0);
    run_traffic(50, 3, 1'b0, 1'b0);
    set_capacity(5'd1);
    run_traffic(50, 3, 1'b1, 1'b0);
    // saturates to the line count, with the receiver backed off
    set_capacity(5'd31);
    run_traffic(80, 24, 1'b0, 1'b1);
    set_capacity(5'd2);
    run_traffic(60, 4, 1'b0, 1'b0);
    set_capacity(5'd16);
    run_traffic(80, 20, 1'b1, 1'b0);
    set_capacity(5'd9);
    run_traffic(70, 12, 1'b0, 1'b0);
    set_capacity(5'd16);
    run_traffic(60, 20, 1'b1, 1'b1);

    drain_and_settle();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
